>>> rtl/prefix_command_to_framed_packet_defines.svh
`ifndef PREFIX_COMMAND_TO_FRAMED_PACKET_DEFINES_SVH
`define PREFIX_COMMAND_TO_FRAMED_PACKET_DEFINES_SVH

// Concurrent checks sampled on clk and disabled while rst_n is low.
`define PCFP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define PCFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pcfp_pkg.sv
package pcfp_pkg;

    localparam int NUM_CMDS = 4;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] match_cnt_t;
    typedef logic [1:0] cmd_idx_t;

    localparam byte_t FRAME_HEADER = 8'hCA;
    localparam byte_t END_MARK     = 8'h2A;

    localparam byte_t CMD_TEXT [NUM_CMDS][8] = '{
        '{8'h23, 8'h4C, 8'h45, 8'h44, 8'h2C, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h43, 8'h46, 8'h47, 8'h2C, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h2C, 8'h00, 8'h00},
        '{8'h23, 8'h43, 8'h54, 8'h52, 8'h2C, 8'h00, 8'h00, 8'h00}
    };

    localparam match_cnt_t CMD_LEN [NUM_CMDS] = '{3'd5, 3'd5, 3'd6, 3'd5};

    localparam byte_t CMD_OPCODE [NUM_CMDS] = '{8'hB5, 8'hB6, 8'hB7, 8'hB8};

endpackage

>>> rtl/prefix_command_to_framed_packet.sv
// Channel | Signals                              | Direction
// input   | in_valid, in_ready, rx_byte          | received characters
// output  | out_valid, out_ready, tx_byte, last_byte | framed packet bytes
//
// Prefix and payload characters are taken one per cycle.
// On '*' the input stalls while the frame goes out: header, opcode and length in turn,
// then each data byte read from the payload memory, then the checksum.
// A frame holds the input until its checksum is registered, and longer on any output stall.
// The output register lets the next item enter while the checksum still waits to be taken.
// Reset clears all control state; the payload memory is not cleared.
`include "prefix_command_to_framed_packet_defines.svh"

module prefix_command_to_framed_packet #(
    parameter int MAX_MSG = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] tx_byte,
    output logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready
);

    localparam int AW = $clog2(MAX_MSG);
    localparam int CW = $clog2(MAX_MSG + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MSG);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLLECT,
        S_HDR,
        S_OP,
        S_LEN,
        S_DATA,
        S_SUM
    } state_t;

    state_t                state_reg, state_next;
    pcfp_pkg::match_cnt_t  cnt_reg  [pcfp_pkg::NUM_CMDS];
    pcfp_pkg::match_cnt_t  cnt_next [pcfp_pkg::NUM_CMDS];
    pcfp_pkg::cmd_idx_t    cmd_reg, cmd_next;
    logic [CW-1:0]         rcv_reg, rcv_next;
    logic [CW-1:0]         len_reg, len_next;
    logic                  zero_reg, zero_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [7:0]            sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            tx_byte_reg, tx_byte_next;
    logic                  last_byte_reg, last_byte_next;

    logic [7:0]            mem [MAX_MSG];
    logic [7:0]            rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    logic                  in_fire;
    logic                  out_free;
    logic [CW-1:0]         rcv_inc;
    logic [CW-1:0]         idx_inc;
    pcfp_pkg::match_cnt_t  cnt_inc;

    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_COLLECT);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_byte_reg;
    assign wr_addr   = rcv_reg[AW-1:0];
    assign rcv_inc   = rcv_reg + CW'(1);
    assign idx_inc   = idx_reg + CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        rcv_next       = rcv_reg;
        len_next       = len_reg;
        zero_next      = zero_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tx_byte_next   = tx_byte_reg;
        last_byte_next = last_byte_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        cnt_inc        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    for (int i = 0; i < pcfp_pkg::NUM_CMDS; i++)
                    begin
                        cnt_inc = cnt_reg[i] + 3'd1;
                        if ((cnt_reg[i] < pcfp_pkg::CMD_LEN[i]) &&
                            (rx_byte == pcfp_pkg::CMD_TEXT[i][cnt_reg[i]]))
                        begin
                            cnt_next[i] = cnt_inc;
                            if (cnt_inc == pcfp_pkg::CMD_LEN[i])
                            begin
                                cmd_next   = pcfp_pkg::cmd_idx_t'(i);
                                state_next = S_COLLECT;
                                rcv_next   = '0;
                                len_next   = '0;
                                zero_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            cnt_next[i] = '0;
                        end
                    end
                end
            end
            S_COLLECT:
            begin
                if (in_fire)
                begin
                    if (rx_byte == pcfp_pkg::END_MARK)
                    begin
                        state_next = S_HDR;
                        cnt_next   = '{default: '0};
                        rcv_next   = '0;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        rcv_next = rcv_inc;
                        if (rx_byte == 8'h00)
                        begin
                            zero_next = 1'b1;
                        end
                        if (!zero_reg && (rx_byte != 8'h00))
                        begin
                            len_next = len_reg + CW'(1);
                        end
                        // drop the command on overflow
                        if (rcv_inc == MAX_CNT)
                        begin
                            state_next = S_IDLE;
                            cnt_next   = '{default: '0};
                        end
                    end
                end
            end
            S_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = pcfp_pkg::FRAME_HEADER;
                    last_byte_next = 1'b0;
                    state_next     = S_OP;
                end
            end
            S_OP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = pcfp_pkg::CMD_OPCODE[cmd_reg];
                    last_byte_next = 1'b0;
                    state_next     = S_LEN;
                end
            end
            S_LEN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = 8'(len_reg);
                    last_byte_next = 1'b0;
                    rd_en          = 1'b1;
                    rd_addr        = '0;
                    idx_next       = '0;
                    sum_next       = '0;
                    state_next     = (len_reg == '0) ? S_SUM : S_DATA;
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = rd_data_reg;
                    last_byte_next = 1'b0;
                    sum_next       = sum_reg + rd_data_reg;
                    idx_next       = idx_inc;
                    rd_en          = 1'b1;
                    rd_addr        = idx_inc[AW-1:0];
                    if (idx_inc == len_reg)
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = sum_reg;
                    last_byte_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '{default: '0};
            cmd_reg       <= '0;
            rcv_reg       <= '0;
            len_reg       <= '0;
            zero_reg      <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            tx_byte_reg   <= '0;
            last_byte_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            rcv_reg       <= rcv_next;
            len_reg       <= len_next;
            zero_reg      <= zero_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            tx_byte_reg   <= tx_byte_next;
            last_byte_reg <= last_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `PCFP_ASSERT_ALWAYS(a_port_excl, !(mem_we && rd_en), "payload write and read collide")
    `PCFP_ASSERT_SAME(a_rcv_range, state_reg == S_COLLECT, rcv_reg < MAX_CNT, "count past limit")
    `PCFP_ASSERT_SAME(a_idx_range, state_reg == S_DATA, idx_reg < len_reg, "read index past length")
    `PCFP_ASSERT_NEXT(a_sum_last, (state_reg == S_SUM) && out_free, out_valid && last_byte, "sum not last")

endmodule
